// ===== rtl/dgv_pkg.sv =====
// Shared types, constants and saturating fixed-point helpers for the double gyre block.
`timescale 1ns / 1ps

package dgv_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [DW-1:0] fix_t;

  // Magnitude product and sign, held between the two halves of a multiply
  typedef struct packed {
    logic            neg;
    logic [2*DW-1:0] mag;
  } prod_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 2'd0,
    REG_AMPLITUDE = 2'd1,
    REG_OMEGA     = 2'd2,
    REG_EPS       = 2'd3
  } cfg_reg_t;

  localparam fix_t VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam fix_t VMIN = {1'b1, {(DW-1){1'b0}}};

  localparam logic [2*DW-FB-1:0] SAT_NEG = (2*DW-FB)'(1) << (DW-1);
  localparam logic [2*DW-FB-1:0] SAT_POS = SAT_NEG - (2*DW-FB)'(1);

  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
  localparam fix_t PI_Q  = DW'((PI_Q61 + (64'd1 << (60-FB))) >> (61-FB));
  localparam fix_t ONE_Q = DW'(64'd1 << FB);

  function automatic logic [DW-1:0] umag(fix_t a);
    return a[DW-1] ? DW'(-a) : DW'(a);
  endfunction

  // First half of a multiply: exact product of the magnitudes
  function automatic prod_t mul_a(fix_t a, fix_t b);
    prod_t p;
    p.neg = a[DW-1] ^ b[DW-1];
    p.mag = {{DW{1'b0}}, umag(a)} * {{DW{1'b0}}, umag(b)};
    return p;
  endfunction

  // Second half: drop fraction bits, saturate, apply sign
  function automatic fix_t mul_b(prod_t p);
    logic [2*DW-FB-1:0] r;
    r = p.mag[2*DW-1:FB];
    if (p.neg) begin
      if (r > SAT_NEG) return VMIN;
      return fix_t'(-r[DW-1:0]);
    end
    if (r > SAT_POS) return VMAX;
    return fix_t'(r[DW-1:0]);
  endfunction

  function automatic fix_t sadd(fix_t a, fix_t b);
    logic [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
    return fix_t'(s[DW-1:0]);
  endfunction

  function automatic fix_t ssub(fix_t a, fix_t b);
    logic [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
    return fix_t'(s[DW-1:0]);
  endfunction

endpackage

// ===== rtl/dgv_trig.sv =====
// Pipelined sine or cosine of a fixed-point angle, 17 register stages.
`timescale 1ns / 1ps

module dgv_trig
  import dgv_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  logic quarter,   // 1 selects cosine
  input  fix_t theta,
  output fix_t result
);

  localparam logic [63:0] INV2PI = 64'h28BE60DB9391054A;
  localparam logic [30:0] HALFPI = 31'd1686629713;
  localparam logic [30:0] ONE    = 31'h4000_0000;
  localparam int NDIV = 5;
  localparam logic [32:0] DIV_M [NDIV] = '{
    33'(((65'd1 << 39) + 65'd109) / 65'd110),
    33'(((65'd1 << 39) + 65'd71) / 65'd72),
    33'(((65'd1 << 38) + 65'd41) / 65'd42),
    33'(((65'd1 << 37) + 65'd19) / 65'd20),
    33'(((65'd1 << 35) + 65'd5) / 65'd6)
  };
  localparam int DIV_K [NDIV] = '{39, 39, 38, 37, 35};

  logic [63:0] pp_lo, pp_hi;
  logic        neg1, neg2;
  logic [31:0] ph2, ph3;
  logic [30:0] r4;
  logic [30:0] x_d  [0:10];
  logic [31:0] x2_d [0:7];
  logic        sgn_d [0:12];
  logic [31:0] num [1:NDIV-1];
  logic [30:0] tq  [0:NDIV-1];
  logic [30:0] s16;

  logic [95:0] ph_sum;
  logic [31:0] qoff;
  logic [61:0] xr_prod, x2_prod, s_prod;
  logic [DW-1:0] v_mag;

  assign ph_sum  = {pp_hi, 32'd0} + {32'd0, pp_lo};
  assign qoff    = quarter ? 32'h4000_0000 : 32'd0;
  assign xr_prod = r4 * HALFPI;
  assign x2_prod = x_d[0] * x_d[0];
  assign s_prod  = x_d[10] * tq[NDIV-1];
  assign v_mag   = DW'(s16 >> (30 - FB));

  always_ff @(posedge clk) begin
    if (en) begin
      // phase in turns: the top 32 fraction bits of |theta| / (2 pi)
      pp_lo <= {32'd0, umag(theta)} * {32'd0, INV2PI[31:0]};
      pp_hi <= {32'd0, umag(theta)} * {32'd0, INV2PI[63:32]};
      neg1  <= theta[DW-1];
      ph2   <= ph_sum[FB+63:FB+32];
      neg2  <= neg1;
      ph3   <= neg2 ? (qoff - ph2) : (ph2 + qoff);
      // fold into the first quadrant
      r4       <= ph3[30] ? (ONE - {1'b0, ph3[29:0]}) : {1'b0, ph3[29:0]};
      sgn_d[0] <= ph3[31];
      x_d[0]   <= xr_prod[60:30];
      x2_d[0]  <= x2_prod[61:30];
      s16      <= s_prod[60:30];
      result   <= sgn_d[12] ? fix_t'(-v_mag) : fix_t'(v_mag);
      for (int k = 1; k <= 10; k++) x_d[k] <= x_d[k-1];
      for (int k = 1; k <= 7; k++) x2_d[k] <= x2_d[k-1];
      for (int k = 1; k <= 12; k++) sgn_d[k] <= sgn_d[k-1];
    end
  end

  // Horner steps of the Taylor series, one multiply per stage
  for (genvar i = 0; i < NDIV; i++) begin : g_horner
    logic [31:0] dn;
    logic [64:0] qp;
    if (i == 0) begin : g_first
      assign dn = x2_d[0];
    end else begin : g_rest
      logic [62:0] up;
      assign up = x2_d[2*i-1] * tq[i-1];
      assign dn = num[i];
      always_ff @(posedge clk) begin
        if (en) begin
          num[i] <= up[61:30];
        end
      end
    end
    assign qp = dn * DIV_M[i];
    always_ff @(posedge clk) begin
      if (en) begin
        tq[i] <= ONE - 31'(qp >> DIV_K[i]);
      end
    end
  end

endmodule

// ===== rtl/double_gyre_velocity_field.sv =====
// Double gyre velocity evaluator: top level with config registers and main pipeline.
`timescale 1ns / 1ps

// Takes one query point per clock while s_tready is high and returns its velocity.
// The pipeline depth is set by two 17-stage sine pipelines in series (omega*t
// first, then pi*f and pi*y) and the two-stage saturating multiplies around them.
// A skid register behind the output register lets the pipeline take one more
// request while a result waits; s_tready drops only while that skid register is
// full. The user must write registers through the cfg port only while the block
// is idle; the block does not enforce this. Writes are taken every cycle.

module double_gyre_velocity_field
  import dgv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [127:0]         s_tdata,   // x_pos, y_pos, z_pos, time_value
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [95:0]          m_tdata,   // vel_first, vel_second, vel_third
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DW-1:0]        cfg_data
);

  localparam int DEPTH = 53;

  logic three_dim_mode;
  fix_t amplitude, angular_frequency, perturbation;

  logic en;
  logic vld [1:DEPTH];

  fix_t  x_d  [1:25];
  fix_t  yc_d [2:28];
  fix_t  g_d  [27:51];
  fix_t  y1, z1, t1, tt2;
  prod_t mp_om3, mp_a22, mp_ax24, mp_a2x25, mp_axx26, mp_bx26;
  prod_t mp_pf29, mp_py29, mp_m48, mp_n48, mp_m50, mp_n50, mp_n52, pa_mp;
  fix_t  theta4, a23, a2_24, b25, b26, ax25, a2x26, axx27, bx27, f28;
  fix_t  pf30, py30, pa, m49, n49, m51, n51, v0_52, v0_53, v1_53;
  fix_t  sin_wt, sin_pf, cos_pf, sin_py, cos_py;
  fix_t  sin_py48, sin_py49, cos_py48, cos_py49;

  logic        out_valid, skid_valid;
  logic [95:0] out_data, skid_data, pack;

  assign cfg_ready = 1'b1;
  assign en        = !skid_valid;
  assign s_tready  = en;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      three_dim_mode    <= 1'b0;
      amplitude         <= fix_t'(6554);
      angular_frequency <= fix_t'(41175);
      perturbation      <= fix_t'(16384);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:      three_dim_mode    <= cfg_data[0];
        REG_AMPLITUDE: amplitude         <= fix_t'(cfg_data);
        REG_OMEGA:     angular_frequency <= fix_t'(cfg_data);
        REG_EPS:       perturbation      <= fix_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // pi*A follows the amplitude register on its own
  always_ff @(posedge clk) begin
    pa_mp <= mul_a(PI_Q, amplitude);
    pa    <= mul_b(pa_mp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= DEPTH; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[1] <= s_tvalid;
      for (int k = 2; k <= DEPTH; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_d[1] <= fix_t'(s_tdata[31:0]);
      y1     <= fix_t'(s_tdata[63:32]);
      z1     <= fix_t'(s_tdata[95:64]);
      t1     <= fix_t'(s_tdata[127:96]);
      for (int k = 2; k <= 25; k++) x_d[k] <= x_d[k-1];
      tt2     <= three_dim_mode ? sadd(t1, y1) : t1;
      yc_d[2] <= three_dim_mode ? z1 : y1;
      for (int k = 3; k <= 28; k++) yc_d[k] <= yc_d[k-1];
      mp_om3 <= mul_a(angular_frequency, tt2);
      theta4 <= mul_b(mp_om3);
      // a = eps * sin(omega t)
      mp_a22   <= mul_a(perturbation, sin_wt);
      a23      <= mul_b(mp_a22);
      a2_24    <= sadd(a23, a23);
      mp_ax24  <= mul_a(a23, x_d[23]);
      b25      <= ssub(ONE_Q, a2_24);
      ax25     <= mul_b(mp_ax24);
      mp_a2x25 <= mul_a(a2_24, x_d[24]);
      mp_axx26 <= mul_a(ax25, x_d[25]);
      mp_bx26  <= mul_a(b25, x_d[25]);
      a2x26    <= mul_b(mp_a2x25);
      b26      <= b25;
      axx27    <= mul_b(mp_axx26);
      bx27     <= mul_b(mp_bx26);
      g_d[27]  <= sadd(a2x26, b26);
      for (int k = 28; k <= 51; k++) g_d[k] <= g_d[k-1];
      f28      <= sadd(axx27, bx27);
      mp_pf29  <= mul_a(PI_Q, f28);
      mp_py29  <= mul_a(PI_Q, yc_d[28]);
      pf30     <= mul_b(mp_pf29);
      py30     <= mul_b(mp_py29);
      // velocity products
      mp_m48   <= mul_a(pa, sin_pf);
      mp_n48   <= mul_a(pa, cos_pf);
      sin_py48 <= sin_py;
      cos_py48 <= cos_py;
      m49      <= mul_b(mp_m48);
      n49      <= mul_b(mp_n48);
      sin_py49 <= sin_py48;
      cos_py49 <= cos_py48;
      mp_m50   <= mul_a(m49, cos_py49);
      mp_n50   <= mul_a(n49, sin_py49);
      m51      <= mul_b(mp_m50);
      n51      <= mul_b(mp_n50);
      v0_52    <= ssub('0, m51);
      mp_n52   <= mul_a(n51, g_d[51]);
      v0_53    <= v0_52;
      v1_53    <= mul_b(mp_n52);
    end
  end

  dgv_trig u_sin_wt (.clk(clk), .en(en), .quarter(1'b0), .theta(theta4), .result(sin_wt));
  dgv_trig u_sin_pf (.clk(clk), .en(en), .quarter(1'b0), .theta(pf30),   .result(sin_pf));
  dgv_trig u_cos_pf (.clk(clk), .en(en), .quarter(1'b1), .theta(pf30),   .result(cos_pf));
  dgv_trig u_sin_py (.clk(clk), .en(en), .quarter(1'b0), .theta(py30),   .result(sin_py));
  dgv_trig u_cos_py (.clk(clk), .en(en), .quarter(1'b1), .theta(py30),   .result(cos_py));

  assign pack = {three_dim_mode ? v1_53 : fix_t'('0),
                 three_dim_mode ? fix_t'('0) : v1_53,
                 v0_53};

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !m_tready) begin
      if (en && vld[DEPTH]) begin
        skid_valid <= 1'b1;
        skid_data  <= pack;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      out_data   <= skid_data;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= vld[DEPTH];
      out_data  <= pack;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with no result in the output register");
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[1])
    else $error("accepted request missing from the first stage");
  a_3d_second_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && three_dim_mode |-> m_tdata[63:32] == '0)
    else $error("middle component nonzero in 3D mode");
  a_2d_third_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !three_dim_mode |-> m_tdata[95:64] == '0)
    else $error("third component nonzero in 2D mode");
`endif

endmodule
